FILE: hw/rtl/stip_pkg.sv
// ----------------------------------------------------------------------------
// stip_pkg: shared types and constants of the signed text to int64 parser
// Holds the request and result payloads, the queue entry and the character
// codes used by the classifier and the conversion engine.
// ----------------------------------------------------------------------------
package stip_pkg;

    localparam int OFFSET_BITS = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [5:0] RADIX_UNARY = 6'd1;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] BASE_AUTO  = 6'd0;
    localparam logic [5:0] BASE_OCT   = 6'd8;
    localparam logic [5:0] BASE_DEC   = 6'd10;
    localparam logic [5:0] BASE_HEX   = 6'd16;
    localparam logic [5:0] DIGIT_NONE = 6'h3F;

    localparam logic [63:0] LIM_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_NEG = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_X  = 8'h58;
    localparam logic [7:0] CH_UC_Z  = 8'h5A;
    localparam logic [7:0] CH_LC_A  = 8'h61;
    localparam logic [7:0] CH_LC_X  = 8'h78;
    localparam logic [7:0] CH_LC_Z  = 8'h7A;
    localparam logic [7:0] UC_BIAS  = 8'd55;
    localparam logic [7:0] LC_BIAS  = 8'd87;

    typedef struct packed {
        logic [7:0] ch;
        logic       start_req;
    } t_in_item;

    typedef struct packed {
        logic signed [63:0]     value;
        logic [OFFSET_BITS-1:0] end_offset;
        logic                   range_error;
        logic                   converted;
    } t_out_item;

    typedef struct packed {
        logic       start;
        logic [5:0] radix;
        logic       radix_bad;
        logic [5:0] digit;
        logic       is_space;
        logic       is_plus;
        logic       is_minus;
        logic       is_x;
        logic       is_zero;
    } t_cls;

    typedef struct packed {
        logic valid;
        t_cls item;
    } t_q_head;

    function automatic logic [5:0] digit_of(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c inside {[CH_ZERO:CH_NINE]}) begin
            v = c - CH_ZERO;
        end else if (c inside {[CH_LC_A:CH_LC_Z]}) begin
            v = c - LC_BIAS;
        end else if (c inside {[CH_UC_A:CH_UC_Z]}) begin
            v = c - UC_BIAS;
        end else begin
            v = {2'b00, DIGIT_NONE};
        end
        return v[5:0];
    endfunction

endpackage

FILE: hw/rtl/stip_front.sv
// ----------------------------------------------------------------------------
// stip_front: character classifier and request queue
// Holds the radix register, classifies each accepted character and places
// it in a small queue that the conversion engine drains.
// ----------------------------------------------------------------------------
module stip_front #(
    parameter int QUEUE_DEPTH = stip_pkg::QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [5:0]         i_cfg_data,
    input  logic               i_in_valid,
    input  stip_pkg::t_in_item i_in_data,
    output logic               o_in_stall,
    input  logic               i_pop,
    output stip_pkg::t_q_head  o_q
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [5:0]       r_radix;
    stip_pkg::t_cls   r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    stip_pkg::t_cls   n_cls;
    logic             w_push;
    logic             w_pop;

    always_comb begin
        n_cls.start     = i_in_data.start_req;
        n_cls.radix     = r_radix;
        n_cls.radix_bad = (r_radix == stip_pkg::RADIX_UNARY) ||
                          (r_radix > stip_pkg::RADIX_MAX);
        n_cls.digit     = stip_pkg::digit_of(i_in_data.ch);
        n_cls.is_space  = i_in_data.ch inside {stip_pkg::CH_SPACE, stip_pkg::CH_TAB,
                                               stip_pkg::CH_LF, stip_pkg::CH_CR,
                                               stip_pkg::CH_FF, stip_pkg::CH_VT};
        n_cls.is_plus   = (i_in_data.ch == stip_pkg::CH_PLUS);
        n_cls.is_minus  = (i_in_data.ch == stip_pkg::CH_MINUS);
        n_cls.is_x      = i_in_data.ch inside {stip_pkg::CH_LC_X, stip_pkg::CH_UC_X};
        n_cls.is_zero   = (i_in_data.ch == stip_pkg::CH_ZERO);
    end

    assign o_in_stall = (r_count == CNT_FULL);
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_pop && (r_count != '0);
    assign o_q.valid  = (r_count != '0);
    assign o_q.item   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= stip_pkg::RADIX_RESET;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_radix <= i_cfg_data;
            end
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= n_cls;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("queue count exceeds depth");

    a_empty_ptrs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_wr_ptr == r_rd_ptr))
        else $error("empty queue with unequal pointers");

endmodule

FILE: hw/rtl/stip_back.sv
// ----------------------------------------------------------------------------
// stip_back: conversion engine
// Runs the parse state machine on classified characters, folds digits with
// saturation and holds the result in an output register.
// ----------------------------------------------------------------------------
module stip_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  stip_pkg::t_q_head   i_q,
    output logic                o_pop,
    output logic                o_out_valid,
    output stip_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_LEAD,
        PH_SIGNED,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS
    } t_phase;

    typedef enum logic [1:0] {
        DS_NONE,
        DS_SOME,
        DS_OVF
    } t_ds;

    t_phase r_phase, n_phase, w_phase;
    t_ds    r_ds, n_ds, w_ds, w_ds_in;
    logic   r_neg, n_neg, w_neg;
    logic [5:0]  r_base, n_base, w_base, w_eb;
    logic [63:0] r_acc, n_acc, w_acc, w_lim;
    logic [stip_pkg::OFFSET_BITS-1:0] r_cnt, n_cnt, w_cnt;
    logic [69:0] w_prod;
    logic   w_adv, w_emit, w_first, w_doe;
    stip_pkg::t_cls      w_it;
    stip_pkg::t_out_item r_out, n_out;
    logic   r_out_valid;

    assign w_it  = i_q.item;
    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_pop = i_q.valid && w_adv;

    always_comb begin
        w_phase = r_phase;
        w_neg   = r_neg;
        w_base  = r_base;
        w_acc   = r_acc;
        w_ds    = r_ds;
        w_cnt   = r_cnt;
        if (w_it.start) begin
            w_phase = PH_LEAD;
            w_neg   = 1'b0;
            w_base  = w_it.radix;
            w_acc   = '0;
            w_ds    = DS_NONE;
            w_cnt   = '0;
        end
        n_phase = w_phase;
        n_neg   = w_neg;
        n_base  = w_base;
        n_acc   = w_acc;
        n_ds    = w_ds;
        n_cnt   = w_cnt;
        w_eb    = w_base;
        w_ds_in = w_ds;
        w_emit  = 1'b0;
        w_first = 1'b0;
        w_doe   = 1'b0;
        w_lim   = w_neg ? stip_pkg::LIM_NEG : stip_pkg::LIM_POS;
        w_prod  = '0;
        if (o_pop) begin
            if (w_it.start && w_it.radix_bad) begin
                w_emit  = 1'b1;
                n_phase = PH_IDLE;
            end else begin
                case (w_phase)
                    PH_LEAD: begin
                        if (w_it.is_space) begin
                            n_phase = PH_LEAD;
                        end else if (w_it.is_minus) begin
                            n_neg   = 1'b1;
                            n_phase = PH_SIGNED;
                        end else if (w_it.is_plus) begin
                            n_phase = PH_SIGNED;
                        end else begin
                            w_first = 1'b1;
                        end
                    end
                    PH_SIGNED: begin
                        w_first = 1'b1;
                    end
                    PH_ZERO: begin
                        if (w_it.is_x) begin
                            n_base  = stip_pkg::BASE_HEX;
                            n_phase = PH_PREFIX;
                        end else begin
                            w_eb    = (w_base == stip_pkg::BASE_AUTO) ?
                                      stip_pkg::BASE_OCT : stip_pkg::BASE_HEX;
                            n_base  = w_eb;
                            w_ds_in = DS_SOME;
                            w_doe   = 1'b1;
                        end
                    end
                    PH_PREFIX, PH_DIGITS: begin
                        w_doe = 1'b1;
                    end
                    default: begin
                        n_phase = w_phase;
                    end
                endcase
                if (w_first) begin
                    if (((w_base == stip_pkg::BASE_AUTO) ||
                         (w_base == stip_pkg::BASE_HEX)) && w_it.is_zero) begin
                        n_phase = PH_ZERO;
                    end else begin
                        w_eb   = (w_base == stip_pkg::BASE_AUTO) ?
                                 stip_pkg::BASE_DEC : w_base;
                        n_base = w_eb;
                        w_doe  = 1'b1;
                    end
                end
                if (w_doe) begin
                    if (w_it.digit >= w_eb) begin
                        w_emit  = 1'b1;
                        n_phase = PH_IDLE;
                        n_ds    = w_ds_in;
                    end else begin
                        n_phase = PH_DIGITS;
                        n_ds    = w_ds_in;
                        if (w_ds_in != DS_OVF) begin
                            w_prod = {6'd0, w_acc} * {64'd0, w_eb} + {64'd0, w_it.digit};
                            if (w_prod > {6'd0, w_lim}) begin
                                n_ds  = DS_OVF;
                                n_acc = w_lim;
                            end else begin
                                n_ds  = DS_SOME;
                                n_acc = w_prod[63:0];
                            end
                        end
                    end
                end
            end
            if (!w_emit && (w_phase != PH_IDLE) && (w_cnt != stip_pkg::OFFSET_MAX)) begin
                n_cnt = w_cnt + 1'b1;
            end
        end
        n_out.value       = w_neg ? (64'd0 - w_acc) : w_acc;
        n_out.end_offset  = (w_ds_in != DS_NONE) ? w_cnt : '0;
        n_out.range_error = (w_ds_in == DS_OVF);
        n_out.converted   = (w_ds_in != DS_NONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_neg       <= 1'b0;
            r_base      <= '0;
            r_acc       <= '0;
            r_ds        <= DS_NONE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
        end else begin
            if (o_pop) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_base  <= n_base;
                r_acc   <= n_acc;
                r_ds    <= n_ds;
                r_cnt   <= n_cnt;
            end
            if (w_adv) begin
                r_out_valid <= o_pop && w_emit;
                r_out       <= n_out;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_none_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.converted) |->
            (o_out_data.value == '0) && (o_out_data.end_offset == '0) &&
            !o_out_data.range_error)
        else $error("result without digits is not zero");

    a_ovf_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ds == DS_OVF) |-> (r_acc == (r_neg ? stip_pkg::LIM_NEG : stip_pkg::LIM_POS)))
        else $error("overflowed accumulator is not at its limit");

    a_none_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ds == DS_NONE) |-> (r_acc == '0))
        else $error("accumulator nonzero before any digit");

endmodule

FILE: hw/rtl/signed_text_to_int64_parser_top.sv
// ----------------------------------------------------------------------------
// signed_text_to_int64_parser_top: streaming text to signed 64-bit integer
//
//   Channel   Direction  Handshake                  Payload
//   request   in         i_in_valid / o_in_stall    i_in_data  (ch, start_req)
//   result    out        o_out_valid / i_out_stall  o_out_data (value, end_offset,
//                                                   range_error, converted)
//   radix     in         i_cfg_we                   i_cfg_data
//
// One character is taken per cycle while the queue is not full; the character
// ending the string passes through the queue and then the output register
// before its result is valid.
// The digit fold is a combinational 64 by 6 bit multiply-add and compare.
// Reset is synchronous and active low; the radix returns to ten.
// Requests stall only when the queue is full; the engine waits on a stalled
// result.
// ----------------------------------------------------------------------------
module signed_text_to_int64_parser_top #(
    parameter int QUEUE_DEPTH = stip_pkg::QUEUE_DEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [5:0]          i_cfg_data,
    input  logic                i_in_valid,
    input  stip_pkg::t_in_item  i_in_data,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output stip_pkg::t_out_item o_out_data,
    input  logic                i_out_stall
);

    stip_pkg::t_q_head w_q;
    logic              w_pop;

    stip_front #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_pop      (w_pop),
        .o_q        (w_q)
    );

    stip_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q         (w_q),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

FILE: bench/tb_signed_text_to_int64_parser_top.sv
// ----------------------------------------------------------------------------
// tb_signed_text_to_int64_parser_top: self-checking bench of the text parser
// A short directed part covers the corner cases of the conversion: whitespace,
// signs, the hex prefix, invalid bases and restarts. Random strings in many
// bases follow. A clocked driver feeds
// requests from a queue, and a clocked monitor predicts each result and
// compares it field by field. Both sides idle in several patterns.
// ----------------------------------------------------------------------------
module tb_signed_text_to_int64_parser_top;
    import stip_pkg::*;

    typedef enum logic [2:0] {
        SCAN_IDLE, SCAN_LEAD, SCAN_SIGNED, SCAN_ZERO, SCAN_PREFIX, SCAN_DIGITS
    } t_scan;

    typedef enum logic [1:0] {DIG_NONE, DIG_SOME, DIG_OVF} t_digits;

    localparam int         NOT_DIGIT = 99;
    localparam int         REPORT_CAP = 100;
    localparam logic [7:0] CH_NUL = 8'h00;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_cfg_we = 1'b0;
    logic [5:0] i_cfg_data = '0;
    logic      i_in_valid = 1'b0;
    t_in_item  i_in_data = '0;
    logic      o_in_stall;
    logic      o_out_valid;
    t_out_item o_out_data;
    logic      i_out_stall = 1'b0;

    signed_text_to_int64_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Parser state as the design should hold it.
    logic [5:0]             radix_model = RADIX_RESET;
    t_scan                  scan = SCAN_IDLE;
    logic                   is_neg = 1'b0;
    logic [5:0]             cur_base = '0;
    logic [63:0]            magnitude = '0;
    t_digits                digits_seen = DIG_NONE;
    logic [OFFSET_BITS-1:0] char_pos = '0;
    logic [63:0]            cut_quot = '0;
    logic [5:0]             cut_digit = '0;

    t_in_item   request_q[$];
    t_out_item  pending_results[$];
    logic [7:0] text_q[$];

    int  n_pushed = 0;
    int  n_accepted = 0;
    int  n_results = 0;
    int  n_cfg = 0;
    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  stall_pct = 0;
    bit  req_fire = 1'b0;

    logic [5:0] radix_plan [0:8] = '{RADIX_RESET, BASE_AUTO, BASE_HEX, RADIX_MAX, 6'd2,
                                     BASE_OCT, RADIX_UNARY, 6'd63, 6'd37};

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR
            || c == CH_FF || c == CH_VT;
    endfunction

    function automatic int char_value(input logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) begin
            return int'(c) - int'(CH_ZERO);
        end
        if (c >= CH_LC_A && c <= CH_LC_Z) begin
            return int'(c) - int'(CH_LC_A) + 10;
        end
        if (c >= CH_UC_A && c <= CH_UC_Z) begin
            return int'(c) - int'(CH_UC_A) + 10;
        end
        return NOT_DIGIT;
    endfunction

    function automatic void set_base(input logic [5:0] b);
        logic [63:0] lim;
        lim = is_neg ? LIM_NEG : LIM_POS;
        if (b < 2) begin
            b = 2;
        end
        cur_base = b;
        cut_quot = lim / b;
        cut_digit = 6'(lim % b);
    endfunction

    function automatic void fold_digit(input int d);
        if (digits_seen == DIG_OVF) begin
            return;
        end
        if (magnitude > cut_quot || (magnitude == cut_quot && d > int'(cut_digit))) begin
            digits_seen = DIG_OVF;
            magnitude = is_neg ? LIM_NEG : LIM_POS;
        end else begin
            digits_seen = DIG_SOME;
            magnitude = magnitude * cur_base + 64'(d);
        end
    endfunction

    function automatic void make_result(output t_out_item r);
        r.value = is_neg ? 64'd0 - magnitude : magnitude;
        r.end_offset = (digits_seen != DIG_NONE) ? char_pos : '0;
        r.range_error = (digits_seen == DIG_OVF);
        r.converted = (digits_seen != DIG_NONE);
    endfunction

    function automatic bit digit_or_end(input logic [7:0] c, output t_out_item r);
        int d;
        r = '0;
        d = char_value(c);
        if (d >= int'(cur_base)) begin
            make_result(r);
            scan = SCAN_IDLE;
            return 1'b1;
        end
        fold_digit(d);
        scan = SCAN_DIGITS;
        return 1'b0;
    endfunction

    function automatic bit first_char(input logic [7:0] c, output t_out_item r);
        r = '0;
        if ((cur_base == BASE_AUTO || cur_base == BASE_HEX) && c == CH_ZERO) begin
            scan = SCAN_ZERO;
            return 1'b0;
        end
        set_base(cur_base == BASE_AUTO ? BASE_DEC : cur_base);
        return digit_or_end(c, r);
    endfunction

    function automatic bit take_char(input logic [7:0] c, output t_out_item r);
        r = '0;
        case (scan)
            SCAN_LEAD: begin
                if (is_blank(c)) begin
                    return 1'b0;
                end
                if (c == CH_MINUS) begin
                    is_neg = 1'b1;
                    scan = SCAN_SIGNED;
                    return 1'b0;
                end
                if (c == CH_PLUS) begin
                    scan = SCAN_SIGNED;
                    return 1'b0;
                end
                return first_char(c, r);
            end
            SCAN_SIGNED: begin
                return first_char(c, r);
            end
            SCAN_ZERO: begin
                if (c == CH_LC_X || c == CH_UC_X) begin
                    set_base(BASE_HEX);
                    scan = SCAN_PREFIX;
                    return 1'b0;
                end
                set_base(cur_base == BASE_AUTO ? BASE_OCT : BASE_HEX);
                fold_digit(0);
                return digit_or_end(c, r);
            end
            SCAN_PREFIX, SCAN_DIGITS: begin
                return digit_or_end(c, r);
            end
            default: begin
                scan = SCAN_IDLE;
                return 1'b0;
            end
        endcase
    endfunction

    function automatic bit parse_request(input t_in_item req, output t_out_item r);
        bit got;
        r = '0;
        if (req.start_req) begin
            scan = SCAN_LEAD;
            is_neg = 1'b0;
            cur_base = radix_model;
            magnitude = '0;
            digits_seen = DIG_NONE;
            char_pos = '0;
            cut_quot = '0;
            cut_digit = '0;
            if (radix_model == RADIX_UNARY || radix_model > RADIX_MAX) begin
                make_result(r);
                scan = SCAN_IDLE;
                return 1'b1;
            end
        end else if (scan == SCAN_IDLE) begin
            return 1'b0;
        end
        got = take_char(req.ch, r);
        if (!got && char_pos != OFFSET_MAX) begin
            char_pos++;
        end
        return got;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < REPORT_CAP) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    always @(negedge i_clk) begin : drive
        t_in_item nxt;
        logic     nxt_valid;
        nxt = i_in_data;
        nxt_valid = i_in_valid;
        if (!i_in_valid || req_fire) begin
            nxt_valid = 1'b0;
            if (i_rst_n && request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                nxt = request_q.pop_front();
                nxt_valid = 1'b1;
            end
        end
        i_in_valid <= nxt_valid;
        i_in_data <= nxt;
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin : watch
        t_out_item want;
        t_out_item seen;
        req_fire = i_rst_n && i_in_valid && !o_in_stall;
        if (req_fire) begin
            n_accepted++;
            if (parse_request(i_in_data, want)) begin
                pending_results.push_back(want);
            end
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen = o_out_data;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("result %0d with none pending", seen.value));
            end else begin
                want = pending_results.pop_front();
                n_results++;
                if (seen.value !== want.value) begin
                    report_mismatch($sformatf("value %0d, expected %0d",
                                              seen.value, want.value));
                end
                if (seen.end_offset !== want.end_offset) begin
                    report_mismatch($sformatf("end_offset %0d, expected %0d",
                                              seen.end_offset, want.end_offset));
                end
                if (seen.range_error !== want.range_error) begin
                    report_mismatch($sformatf("range_error %0b, expected %0b",
                                              seen.range_error, want.range_error));
                end
                if (seen.converted !== want.converted) begin
                    report_mismatch($sformatf("converted %0b, expected %0b",
                                              seen.converted, want.converted));
                end
            end
        end
    end

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10) begin
            return CH_ZERO + 8'(d);
        end
        return ($urandom_range(1) ? CH_UC_A : CH_LC_A) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] blank_char();
        case ($urandom_range(5))
            0: return CH_SPACE;
            1: return CH_TAB;
            2: return CH_LF;
            3: return CH_CR;
            4: return CH_FF;
            default: return CH_VT;
        endcase
    endfunction

    task automatic put(input logic [7:0] c, input bit s);
        t_in_item req;
        req.ch = c;
        req.start_req = s;
        request_q.push_back(req);
        n_pushed++;
    endtask

    task automatic send_text(input bit with_start);
        foreach (text_q[k]) begin
            put(text_q[k], with_start && k == 0);
        end
        text_q.delete();
    endtask

    task automatic add_str(input string s);
        foreach (s[k]) begin
            text_q.push_back(s[k]);
        end
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (n_pushed != n_accepted || pending_results.size() != 0);
    endtask

    task automatic finish_phase();
        wait_drained();
        if (scan != SCAN_IDLE) begin
            @(posedge i_clk);
            put(CH_NUL, 1'b0);
            wait_drained();
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_radix(input logic [5:0] v);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        radix_model = v;
        n_cfg++;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic add_string(input logic [5:0] rdx);
        int          kind;
        int          eb;
        int          nd;
        int          at;
        int          sign;
        logic [63:0] m;
        logic [7:0]  c;
        kind = $urandom_range(15);
        if (rdx == RADIX_UNARY || rdx > RADIX_MAX) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom));
            send_text(1'b1);
            return;
        end
        if (kind >= 13) begin
            repeat ($urandom_range(1, 6)) text_q.push_back(8'($urandom));
            send_text(kind != 15);
            return;
        end
        if ($urandom_range(3) == 0) begin
            repeat ($urandom_range(1, 3)) text_q.push_back(blank_char());
        end
        sign = $urandom_range(2);
        if (kind == 12 && sign == 0) begin
            sign = 1;
        end
        if (sign != 0) begin
            text_q.push_back(sign == 2 ? CH_MINUS : CH_PLUS);
        end
        if (kind == 12) begin
            text_q.push_back(blank_char());
        end
        eb = rdx;
        if (rdx == BASE_AUTO) begin
            case ($urandom_range(2))
                0: eb = 10;
                1: begin
                    eb = 8;
                    text_q.push_back(CH_ZERO);
                end
                default: eb = 16;
            endcase
        end
        if (eb == 16 && (rdx == BASE_AUTO || kind == 11 || $urandom_range(1))) begin
            text_q.push_back(CH_ZERO);
            text_q.push_back($urandom_range(1) ? CH_UC_X : CH_LC_X);
        end
        if (kind != 11 && $urandom_range(4) == 0) begin
            repeat ($urandom_range(1, 2)) text_q.push_back(CH_ZERO);
        end
        if (kind >= 5 && kind <= 8) begin
            m = (sign == 2) ? LIM_NEG : LIM_POS;
            case ($urandom_range(4))
                0: ;
                1: m = m - 1;
                2: m = m + 1;
                3: m = {$urandom, $urandom};
                default: m = 64'($urandom_range(1000));
            endcase
            at = text_q.size();
            do begin
                text_q.insert(at, digit_char(int'(m % 64'(eb))));
                m = m / 64'(eb);
            end while (m != 0);
            nd = ($urandom_range(3) == 0) ? $urandom_range(1, 2) : 0;
        end else if (kind == 11) begin
            nd = 0;
        end else if (kind == 9) begin
            nd = $urandom_range(15, 25);
        end else begin
            nd = $urandom_range(1, 6);
        end
        repeat (nd) text_q.push_back(digit_char($urandom_range(eb - 1)));
        if (kind != 10) begin
            if ($urandom_range(3) == 0) begin
                c = CH_NUL;
            end else begin
                do c = 8'($urandom_range(255));
                while (char_value(c) < eb);
            end
            text_q.push_back(c);
            repeat ($urandom_range(2)) text_q.push_back(8'($urandom));
        end
        send_text(1'b1);
    endtask

    initial begin : stimulus
        logic [5:0] rdx;
        int         seg_start;
        int         budget;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // The reset base of ten is used first.
        put(8'hFF, 1'b1);
        put(CH_NUL, 1'b0);
        add_str("- 5");
        send_text(1'b1);
        add_str("12");
        send_text(1'b1);
        add_str("7");
        text_q.push_back(CH_NUL);
        send_text(1'b1);
        text_q = '{CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR, CH_SPACE};
        add_str("+3");
        text_q.push_back(CH_NUL);
        send_text(1'b1);
        finish_phase();

        write_radix(BASE_AUTO);
        add_str("0xg");
        send_text(1'b1);
        add_str("-0179");
        send_text(1'b1);
        finish_phase();
        write_radix(BASE_HEX);
        add_str("0XfF");
        text_q.push_back(CH_NUL);
        send_text(1'b1);
        finish_phase();
        write_radix(RADIX_MAX);
        add_str("zZ.");
        send_text(1'b1);
        finish_phase();
        write_radix(RADIX_UNARY);
        add_str("A");
        send_text(1'b1);
        finish_phase();
        write_radix(6'd63);
        add_str("55");
        send_text(1'b1);
        finish_phase();
        write_radix(6'd2);
        add_str("12");
        send_text(1'b1);
        finish_phase();

        for (int s = 0; s < 16; s++) begin
            case (s % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                end
                1: begin
                    send_idle_pct = 85;
                    stall_pct = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct = 85;
                end
                default: begin
                    send_idle_pct = 30;
                    stall_pct = 30;
                end
            endcase
            if (s < 9) begin
                rdx = radix_plan[s];
            end else if ($urandom_range(4) == 0) begin
                rdx = 6'($urandom_range(63));
            end else begin
                rdx = 6'($urandom_range(36));
            end
            write_radix(rdx);
            budget = (rdx == RADIX_UNARY || rdx > RADIX_MAX) ? 30 : 120;
            seg_start = n_pushed;
            while (n_pushed - seg_start < budget) begin
                add_string(rdx);
            end
            finish_phase();
        end

        repeat (8) @(negedge i_clk);
        $display("Checked %0d results from %0d requests over %0d radix writes,",
                 n_results, n_accepted, n_cfg);
        $display("with bursts, sender gaps, receiver stalls, restarts and invalid bases.");
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
